// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker module of the packetizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with reset disable; prop is any property expression.
`define TRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define TRP_ASSERT_NOW(lbl, ante, cons, msg) \
  `TRP_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication.
`define TRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  `TRP_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// File: rtl/core/trp_pkg.sv
// Shared constants and helpers of the typed record packetizer.
package trp_pkg;

  localparam int MaxPacket  = 64;
  localparam int TypeCount  = 4;
  localparam int TypeW      = 2;
  localparam int PtrW       = 6;
  localparam int AddrW      = TypeW + PtrW;
  localparam int StoreDepth = TypeCount * MaxPacket;
  localparam int LimW       = 7;
  localparam int SeqW       = 32;
  localparam int ByteW      = 8;
  localparam int HdrLen     = 5;
  localparam int MinLimit   = 6;
  localparam int LimitReset = 64;

  // Stream payload widths
  localparam int InDataW  = 16;
  localparam int InUserW  = TypeW;
  localparam int OutDataW = ByteW;
  localparam int OutUserW = 1;

  // Effective packet limit: register clamped to MinLimit..MaxPacket.
  function automatic logic [LimW-1:0] clamp_limit(logic [LimW-1:0] raw);
    logic [LimW-1:0] lim;
    lim = raw;
    if (raw < LimW'(MinLimit)) lim = LimW'(MinLimit);
    if (raw > LimW'(MaxPacket)) lim = LimW'(MaxPacket);
    return lim;
  endfunction

endpackage

// File: rtl/core/trp_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module trp_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/typed_record_packetizer_core.sv
// Typed record packetizer: top level with per-type packet buffers in one RAM.
//
// Input stream (s_axis_*): one record byte per transfer. tuser carries the record
// type, tdata carries the byte, a record-start flag and the record length.
// Output stream (m_axis_*): bytes of completed packets, header first; tlast marks
// the final byte, tuser carries the sticky drop flag.
// Config channel (cfg_*): writes the packet limit; always ready, write it only
// while the block is idle. Limit is clamped to 6..64 internally.
//
// A byte that does not trigger a flush is stored (or dropped when its packet is
// full) as it is taken, and the next input transfer can be taken in the following
// cycle. A byte that starts a record which no longer fits flushes that type's
// packet (header only if none is open): the block stops taking input and walks
// the packet byte by byte, a read step and then a load into the output register,
// header bytes from the job registers and the rest through the single RAM read
// port; s_axis_tready stays low until the last byte is loaded.
// The last flushed byte sits in the output register while new input is taken.
// A stalled receiver simply holds the output register and pauses the walk.
// Reset clears all control state, fill counts, sequence numbers and the drop
// flag; the packet RAM needs no clearing since it is read only after writes.
module typed_record_packetizer_core
  import trp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [7:0] data_byte, [8] record_start, [15:9] record_len
  input  logic [InDataW-1:0]  s_axis_tdata,
  // [1:0] record_type
  input  logic [InUserW-1:0]  s_axis_tuser,
  // Output stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [7:0] out_byte
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tlast,
  // [0] dropped_seen
  output logic [OutUserW-1:0] m_axis_tuser,
  // Config write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [LimW-1:0]     cfg_data_i
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StLoad = 2'd2;

  // Control and per-type state
  logic [1:0]       state_q, state_d;
  logic [LimW-1:0]  limit_q;
  logic [LimW-1:0]  fill_q [TypeCount];
  logic             open_q [TypeCount];
  logic [SeqW-1:0]  seq_q  [TypeCount];
  logic             drop_q;

  // Flush job
  logic [TypeW-1:0] job_type_q;
  logic [SeqW-1:0]  job_seq_q;
  logic [LimW-1:0]  job_cnt_q;
  logic [PtrW-1:0]  job_idx_q;
  logic [ByteW-1:0] job_byte_q;

  // Output register
  logic             out_valid_q;
  logic [ByteW-1:0] out_byte_q;
  logic             out_last_q;
  logic             out_drop_q;

  // Input fields
  logic [TypeW-1:0] in_type;
  logic [ByteW-1:0] in_byte;
  logic             in_start;
  logic [LimW-1:0]  in_len;

  assign in_type  = s_axis_tuser;
  assign in_byte  = s_axis_tdata[7:0];
  assign in_start = s_axis_tdata[8];
  assign in_len   = s_axis_tdata[15:9];

  // Accept-time decode
  logic             in_xfer;
  logic [LimW-1:0]  lim;
  logic             cur_open;
  logic [LimW-1:0]  cur_fill;
  logic [SeqW-1:0]  cur_seq;
  logic [LimW:0]    fill_sum;
  logic             need_flush;
  logic             has_room;
  logic [1:0]       seq_inc;
  logic [SeqW-1:0]  new_seq;
  logic [SeqW-1:0]  hdr_seq;

  assign s_axis_tready = (state_q == StIdle);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign lim           = clamp_limit(limit_q);
  assign cur_open      = open_q[in_type];
  assign cur_fill      = cur_open ? fill_q[in_type] : LimW'(HdrLen);
  assign cur_seq       = seq_q[in_type];
  assign fill_sum      = {1'b0, cur_fill} + {1'b0, in_len};
  assign need_flush    = in_start && (fill_sum > {1'b0, lim});
  assign has_room      = cur_fill < lim;
  assign seq_inc       = {1'b0, !cur_open} + {1'b0, need_flush};
  assign new_seq       = cur_seq + {{(SeqW-2){1'b0}}, seq_inc};
  // Header sequence of the packet being flushed
  assign hdr_seq       = cur_open ? (cur_seq - {{(SeqW-1){1'b0}}, 1'b1}) : cur_seq;

  // Flush walk
  logic             load_ok;
  logic             walk_last;
  logic [ByteW-1:0] hdr_byte;
  logic [ByteW-1:0] walk_byte;
  logic [ByteW-1:0] ram_rdata;

  assign load_ok   = (state_q == StLoad) && (!out_valid_q || m_axis_tready);
  assign walk_last = ({1'b0, job_idx_q} == (job_cnt_q - LimW'(1)));

  // Header bytes: type, then sequence number low byte first
  always_comb begin
    case (job_idx_q[2:0])
      3'd0:    hdr_byte = {{(ByteW-TypeW){1'b0}}, job_type_q};
      3'd1:    hdr_byte = job_seq_q[7:0];
      3'd2:    hdr_byte = job_seq_q[15:8];
      3'd3:    hdr_byte = job_seq_q[23:16];
      3'd4:    hdr_byte = job_seq_q[31:24];
      default: hdr_byte = '0;
    endcase
  end

  assign walk_byte = (job_idx_q < PtrW'(HdrLen)) ? hdr_byte : ram_rdata;

  // RAM port control
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [ByteW-1:0] ram_wdata;
  logic             ram_re;
  logic [AddrW-1:0] ram_raddr;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {in_type, cur_fill[PtrW-1:0]};
    ram_wdata = in_byte;
    if (in_xfer && !need_flush && has_room) begin
      ram_we = 1'b1;
    end else if (load_ok && walk_last) begin
      // Append of the byte that triggered the flush, after the walk is done
      ram_we    = 1'b1;
      ram_waddr = {job_type_q, PtrW'(HdrLen)};
      ram_wdata = job_byte_q;
    end
  end

  assign ram_re    = (state_q == StRead);
  assign ram_raddr = {job_type_q, job_idx_q};

  trp_ram #(
    .Width (ByteW),
    .Depth (StoreDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_xfer && need_flush) state_d = StRead;
      end
      StRead: begin
        state_d = StLoad;
      end
      StLoad: begin
        if (load_ok) state_d = walk_last ? StIdle : StRead;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control and per-type state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      limit_q <= LimW'(LimitReset);
      drop_q  <= 1'b0;
      for (int i = 0; i < TypeCount; i++) begin
        fill_q[i] <= '0;
        open_q[i] <= 1'b0;
        seq_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
      if (in_xfer) begin
        open_q[in_type] <= 1'b1;
        seq_q[in_type]  <= new_seq;
        if (!need_flush) begin
          if (has_room) begin
            fill_q[in_type] <= cur_fill + LimW'(1);
          end else begin
            fill_q[in_type] <= cur_fill;
            drop_q          <= 1'b1;
          end
        end
      end
      if (load_ok && walk_last) begin
        fill_q[job_type_q] <= LimW'(HdrLen + 1);
      end
    end
  end

  // Flush job registers
  always_ff @(posedge clk_i) begin
    if (in_xfer && need_flush) begin
      job_type_q <= in_type;
      job_seq_q  <= hdr_seq;
      job_cnt_q  <= cur_fill;
      job_byte_q <= in_byte;
      job_idx_q  <= '0;
    end else if (load_ok && !walk_last) begin
      job_idx_q <= job_idx_q + PtrW'(1);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_ok) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_ok) begin
      out_byte_q <= walk_byte;
      out_last_q <= walk_last;
      out_drop_q <= drop_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_drop_q;
  assign cfg_ready_o   = 1'b1;

endmodule

// File: rtl/core/trp_checker.sv
// Port-level checker for the typed record packetizer, bound to the top level.
`include "assert_macros.svh"

module trp_checker
  import trp_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [InDataW-1:0]  s_axis_tdata,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tlast,
  input logic [OutUserW-1:0] m_axis_tuser
);

  // A stalled output transfer keeps its byte
  `TRP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output changed under stall")

  // Input stays closed while a packet is only partly handed over
  `TRP_ASSERT_NOW(a_mid_packet_busy, m_axis_tvalid && !m_axis_tlast, !s_axis_tready,
    "input open during flush")

  // A byte that does not start a record never starts a flush
  `TRP_ASSERT_NEXT(a_plain_byte_fast, s_axis_tvalid && s_axis_tready && !s_axis_tdata[8],
    s_axis_tready, "plain byte stalled input")

  // Drop flag is sticky across output transfers
  `TRP_ASSERT_NEXT(a_drop_sticky, m_axis_tvalid && m_axis_tready && m_axis_tuser[0],
    !m_axis_tvalid || m_axis_tuser[0], "drop flag cleared")

endmodule

bind typed_record_packetizer_core trp_checker u_trp_checker (.*);

// File: bench/tb_typed_record_packetizer_core.sv
// Self-checking testbench for the typed record packetizer core.
module tb_typed_record_packetizer_core;
  import trp_pkg::*;

  localparam int QuietLimit   = 4000;  // cycles with no transfer before giving up
  localparam int SettleCycles = 4;
  localparam int TailCycles   = 20;
  localparam int PhaseItems   = 63;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e  kind;
    logic [1:0] rtype;
    logic [7:0] dbyte;
    logic       start;
    logic [6:0] len;
    logic [6:0] limit;
    logic       chk;       // typed expectation present
    int         exp_n;     // bytes flushed by this row
    logic [7:0] exp_tail;  // final flushed byte
    logic       exp_drop;
  } row_t;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
    logic             drop;
  } pkt_byte_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [InUserW-1:0]  s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;
  logic [OutUserW-1:0] m_axis_tuser;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [LimW-1:0]     cfg_data_i;

  typed_record_packetizer_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  // Predictor state: one packet buffer per record type
  logic [ByteW-1:0] pkt_mem [TypeCount][MaxPacket];
  int               pkt_fill [TypeCount];
  logic             pkt_open [TypeCount];
  logic [SeqW-1:0]  pkt_seq  [TypeCount];
  logic             drop_sticky;
  logic [LimW-1:0]  limit_reg;

  pkt_byte_t pending_bytes[$];  // packet bytes still owed by the block
  int        mism_cnt;
  int        send_idle_pct;
  int        recv_stall_pct;
  int        quiet_cycles;

  // Directed rows; tails read straight off the header layout and stored bytes
  row_t dir_rows [0:18] = '{
    '{ROW_CFG,  2'd0, 8'h00, 1'b0, 7'd0,  7'd6,   1'b0, 0, 8'h00, 1'b0},
    '{ROW_ITEM, 2'd0, 8'h00, 1'b1, 7'd1,  7'd0,   1'b1, 0, 8'h00, 1'b0},
    '{ROW_ITEM, 2'd0, 8'hFF, 1'b1, 7'd1,  7'd0,   1'b1, 6, 8'h00, 1'b0},
    '{ROW_ITEM, 2'd1, 8'h3C, 1'b0, 7'd0,  7'd0,   1'b1, 0, 8'h00, 1'b0},
    '{ROW_ITEM, 2'd1, 8'h42, 1'b1, 7'd0,  7'd0,   1'b1, 0, 8'h00, 1'b1},  // full: dropped
    '{ROW_ITEM, 2'd3, 8'h5A, 1'b1, 7'd64, 7'd0,   1'b1, 5, 8'h00, 1'b1},  // header-only flush
    '{ROW_ITEM, 2'd2, 8'h81, 1'b1, 7'd1,  7'd0,   1'b0, 0, 8'h00, 1'b0},
    '{ROW_CFG,  2'd0, 8'h00, 1'b0, 7'd0,  7'd127, 1'b0, 0, 8'h00, 1'b0},  // clamps to max
    '{ROW_ITEM, 2'd3, 8'h01, 1'b1, 7'd58, 7'd0,   1'b1, 0, 8'h00, 1'b1},  // exactly fits
    '{ROW_ITEM, 2'd3, 8'hC3, 1'b0, 7'd0,  7'd0,   1'b0, 0, 8'h00, 1'b0},
    '{ROW_CFG,  2'd0, 8'h00, 1'b0, 7'd0,  7'd0,   1'b0, 0, 8'h00, 1'b0},  // clamps to min
    '{ROW_ITEM, 2'd3, 8'h77, 1'b0, 7'd0,  7'd0,   1'b1, 0, 8'h00, 1'b1},  // fill above limit
    '{ROW_ITEM, 2'd3, 8'h88, 1'b1, 7'd0,  7'd0,   1'b1, 8, 8'hC3, 1'b1},
    '{ROW_CFG,  2'd0, 8'h00, 1'b0, 7'd0,  7'd64,  1'b0, 0, 8'h00, 1'b0},
    '{ROW_ITEM, 2'd2, 8'h7E, 1'b1, 7'd64, 7'd0,   1'b1, 6, 8'h81, 1'b1},
    '{ROW_ITEM, 2'd2, 8'hE7, 1'b1, 7'd58, 7'd0,   1'b0, 0, 8'h00, 1'b0},
    '{ROW_ITEM, 2'd1, 8'h18, 1'b1, 7'd63, 7'd0,   1'b1, 6, 8'h3C, 1'b1},
    '{ROW_CFG,  2'd0, 8'h00, 1'b0, 7'd0,  7'd40,  1'b0, 0, 8'h00, 1'b0},
    '{ROW_ITEM, 2'd0, 8'h55, 1'b1, 7'd40, 7'd0,   1'b1, 6, 8'hFF, 1'b1}
  };

  function automatic void note_mismatch(string msg);
    mism_cnt++;
    if (mism_cnt <= 10) $display("%s", msg);
  endfunction

  // Start a fresh packet: type byte, then sequence number LSB first
  function automatic void open_pkt(logic [1:0] t);
    pkt_mem[t][0] = ByteW'(t);
    for (int i = 0; i < 4; i++) pkt_mem[t][1+i] = pkt_seq[t][8*i +: 8];
    pkt_seq[t]  = pkt_seq[t] + 1'b1;
    pkt_fill[t] = HdrLen;
    pkt_open[t] = 1'b1;
  endfunction

  // Apply one input byte; queue the flushed packet bytes, return their count
  function automatic int packetize_byte(logic [1:0] t, logic [7:0] b, logic s,
                                        logic [6:0] l);
    int lim;
    int n;
    lim = (limit_reg < MinLimit) ? MinLimit :
          (limit_reg > MaxPacket) ? MaxPacket : int'(limit_reg);
    n = 0;
    if (!pkt_open[t]) open_pkt(t);
    if (s && (pkt_fill[t] + int'(l) > lim)) begin
      n = pkt_fill[t];
      for (int i = 0; i < n; i++)
        pending_bytes.insert(pending_bytes.size(),
                             pkt_byte_t'{data: pkt_mem[t][i], last: (i == n - 1), drop: 1'b0});
      open_pkt(t);
    end
    if (pkt_fill[t] < lim) begin
      pkt_mem[t][pkt_fill[t]] = b;
      pkt_fill[t]++;
    end else begin
      drop_sticky = 1'b1;
    end
    // drop flag reported as it stands after this byte
    for (int k = 0; k < n; k++)
      pending_bytes[pending_bytes.size() - n + k].drop = drop_sticky;
    return n;
  endfunction

  // One input transfer, with random idle gaps ahead of it
  task automatic send_item(input logic [1:0] t, input logic [7:0] b, input logic s,
                           input logic [6:0] l, output int n);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {l, s, b};
    s_axis_tuser  <= t;
    do @(posedge clk_i); while (!s_axis_tready);
    n = packetize_byte(t, b, s, l);
  endtask

  // Hold input until every owed byte is out and the block is quiet
  task automatic drain_output();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_bytes.size() != 0);
  endtask

  task automatic write_limit(input logic [LimW-1:0] v);
    drain_output();
    repeat (SettleCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    limit_reg   = v;
    cfg_valid_i <= 1'b0;
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Receiver backpressure
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Output checker: each byte against the oldest owed one
  always @(posedge clk_i) begin : chk_out
    pkt_byte_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_bytes.size() == 0) begin
        note_mismatch($sformatf("unexpected output: data %h last %b drop %b",
                                m_axis_tdata, m_axis_tlast, m_axis_tuser[0]));
      end else begin
        want = pending_bytes.pop_front();
        if (want.data !== m_axis_tdata || want.last !== m_axis_tlast ||
            want.drop !== m_axis_tuser[0])
          note_mismatch($sformatf("output mismatch: exp %h/%b/%b got %h/%b/%b",
                                  want.data, want.last, want.drop,
                                  m_axis_tdata, m_axis_tlast, m_axis_tuser[0]));
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Stimulus
  initial begin : stim
    int n;
    int cnt;
    int rlen;
    int nbytes;
    logic [1:0] rt;
    int phase_idle  [4] = '{0, 45, 0, 18};
    int phase_stall [4] = '{0, 0, 45, 18};

    rst_ni         <= 1'b0;
    s_axis_tvalid  <= 1'b0;
    s_axis_tdata   <= '0;
    s_axis_tuser   <= '0;
    cfg_valid_i    <= 1'b0;
    cfg_data_i     <= '0;
    mism_cnt       = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    drop_sticky    = 1'b0;
    limit_reg      = LimitReset;
    for (int t = 0; t < TypeCount; t++) begin
      pkt_fill[t] = 0;
      pkt_open[t] = 1'b0;
      pkt_seq[t]  = '0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows: limits at and beyond both ends, flush corner cases
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_limit(dir_rows[i].limit);
      end else begin
        send_item(dir_rows[i].rtype, dir_rows[i].dbyte, dir_rows[i].start,
                  dir_rows[i].len, n);
        if (dir_rows[i].chk &&
            (n != dir_rows[i].exp_n || drop_sticky != dir_rows[i].exp_drop ||
             (n > 0 && pending_bytes[$].data != dir_rows[i].exp_tail)))
          note_mismatch($sformatf("row %0d: flush of %0d bytes, expected %0d",
                                  i, n, dir_rows[i].exp_n));
      end
    end

    // Random phases: mostly whole records, some stray bytes
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_limit(7'd64);
        1: write_limit(7'd6);
        2: write_limit(7'($urandom_range(7, 63)));
        default: write_limit(7'($urandom_range(0, 127)));
      endcase
      send_idle_pct  = phase_idle[ph];
      recv_stall_pct = phase_stall[ph];
      cnt = 0;
      while (cnt < PhaseItems) begin
        rt = 2'($urandom_range(TypeCount - 1));
        if ($urandom_range(9) == 0) begin
          // stray byte with arbitrary start and length
          send_item(rt, 8'($urandom), 1'($urandom), 7'($urandom_range(0, 64)), n);
          cnt++;
        end else begin
          rlen   = ($urandom_range(9) < 7) ? $urandom_range(1, 12) : $urandom_range(0, 64);
          nbytes = (rlen == 0) ? 1 : rlen;
          for (int j = 0; j < nbytes; j++) begin
            send_item(rt, 8'($urandom), (j == 0), (j == 0) ? 7'(rlen) : 7'($urandom), n);
            cnt++;
          end
        end
        // let the packet pipe empty completely once
        if (ph == 1 && cnt >= PhaseItems / 2 && cnt < PhaseItems / 2 + 13) begin
          drain_output();
          cnt = PhaseItems / 2 + 13;
        end
      end
    end

    drain_output();
    repeat (TailCycles) @(posedge clk_i);
    if (mism_cnt == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// File: typed_record_packetizer_core.f
+incdir+rtl/core
rtl/core/trp_pkg.sv
rtl/core/trp_ram.sv
rtl/core/typed_record_packetizer_core.sv
rtl/core/trp_checker.sv
bench/tb_typed_record_packetizer_core.sv
